// File: hdl/admissible_tuple_checker_macros.svh
// Assertion macros used by the admissible tuple checker RTL.
`ifndef ADMISSIBLE_TUPLE_CHECKER_MACROS_SVH
`define ADMISSIBLE_TUPLE_CHECKER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ATC_HOLDS(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ATC_FOLLOWS(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/atc_pkg.sv
// Shared types, constants and the prime table of the admissible tuple checker.
`default_nettype none

package atc_pkg;

  localparam int unsigned MAX_OFFSETS = 168;
  localparam int unsigned PRIME_COUNT = 168;
  localparam int unsigned MARK_DEPTH  = 1024;

  localparam int unsigned OFFSET_W    = 32;
  localparam int unsigned COUNT_W     = 8;
  localparam int unsigned STORE_AW    = $clog2(MAX_OFFSETS);
  localparam int unsigned MARK_AW     = $clog2(MARK_DEPTH);
  localparam int unsigned PRIME_W     = 10;
  localparam int unsigned PRIME_IDX_W = 8;
  localparam int unsigned STEP_W      = 4;

  localparam int unsigned MOD_DIGIT_W = 4;
  localparam int unsigned MOD_CYCLES  = OFFSET_W / MOD_DIGIT_W;
  localparam int unsigned MOD_CNT_W   = $clog2(MOD_CYCLES);

  localparam logic [PRIME_W-1:0] PRIME_TABLE [PRIME_COUNT] = '{
    10'd2,   10'd3,   10'd5,   10'd7,   10'd11,  10'd13,  10'd17,  10'd19,
    10'd23,  10'd29,  10'd31,  10'd37,  10'd41,  10'd43,  10'd47,  10'd53,
    10'd59,  10'd61,  10'd67,  10'd71,  10'd73,  10'd79,  10'd83,  10'd89,
    10'd97,  10'd101, 10'd103, 10'd107, 10'd109, 10'd113, 10'd127, 10'd131,
    10'd137, 10'd139, 10'd149, 10'd151, 10'd157, 10'd163, 10'd167, 10'd173,
    10'd179, 10'd181, 10'd191, 10'd193, 10'd197, 10'd199, 10'd211, 10'd223,
    10'd227, 10'd229, 10'd233, 10'd239, 10'd241, 10'd251, 10'd257, 10'd263,
    10'd269, 10'd271, 10'd277, 10'd281, 10'd283, 10'd293, 10'd307, 10'd311,
    10'd313, 10'd317, 10'd331, 10'd337, 10'd347, 10'd349, 10'd353, 10'd359,
    10'd367, 10'd373, 10'd379, 10'd383, 10'd389, 10'd397, 10'd401, 10'd409,
    10'd419, 10'd421, 10'd431, 10'd433, 10'd439, 10'd443, 10'd449, 10'd457,
    10'd461, 10'd463, 10'd467, 10'd479, 10'd487, 10'd491, 10'd499, 10'd503,
    10'd509, 10'd521, 10'd523, 10'd541, 10'd547, 10'd557, 10'd563, 10'd569,
    10'd571, 10'd577, 10'd587, 10'd593, 10'd599, 10'd601, 10'd607, 10'd613,
    10'd617, 10'd619, 10'd631, 10'd641, 10'd643, 10'd647, 10'd653, 10'd659,
    10'd661, 10'd673, 10'd677, 10'd683, 10'd691, 10'd701, 10'd709, 10'd719,
    10'd727, 10'd733, 10'd739, 10'd743, 10'd751, 10'd757, 10'd761, 10'd769,
    10'd773, 10'd787, 10'd797, 10'd809, 10'd811, 10'd821, 10'd823, 10'd827,
    10'd829, 10'd839, 10'd853, 10'd857, 10'd859, 10'd863, 10'd877, 10'd881,
    10'd883, 10'd887, 10'd907, 10'd911, 10'd919, 10'd929, 10'd937, 10'd941,
    10'd947, 10'd953, 10'd967, 10'd971, 10'd977, 10'd983, 10'd991, 10'd997
  };

  typedef enum logic [3:0] {
    COND_NEVER       = 4'd0,
    COND_ALWAYS      = 4'd1,
    COND_NO_START    = 4'd2,
    COND_OVERFLOW    = 4'd3,
    COND_P_GT_N      = 4'd4,
    COND_R_NOT_LAST  = 4'd5,
    COND_MOD_BUSY    = 4'd6,
    COND_K_NOT_LAST  = 4'd7,
    COND_MARK_CLEAR  = 4'd8,
    COND_R_NE_P      = 4'd9,
    COND_OUT_BLOCKED = 4'd10
  } cond_e;

  typedef struct packed {
    logic              in_open;
    logic              mark_we;
    logic              mark_bit;
    logic              mark_from_rem;
    logic              r_clr;
    logic              r_inc;
    logic              k_clr;
    logic              k_inc;
    logic              i_clr;
    logic              i_inc;
    logic              p_load;
    logic              mod_start;
    logic              res_set;
    logic              res_clr;
    logic              out_load;
    cond_e             cond;
    logic [STEP_W-1:0] target;
  } ctrl_t;

  typedef struct packed {
    logic start;
    logic overflow;
    logic p_gt_n;
    logic r_not_last;
    logic mod_busy;
    logic k_not_last;
    logic mark_clear;
    logic r_ne_p;
    logic out_blocked;
  } status_t;

  function automatic logic [PRIME_W-1:0] prime_at(input logic [PRIME_IDX_W-1:0] idx);
    if (idx < PRIME_IDX_W'(PRIME_COUNT)) begin
      return PRIME_TABLE[idx];
    end
    return '1;
  endfunction

endpackage

`default_nettype wire

// File: hdl/atc_ram.sv
// Generic single-write, single-read RAM with a registered read port.
`default_nettype none

module atc_ram #(
  parameter int unsigned WIDTH = 1,
  parameter int unsigned DEPTH = 2,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// File: hdl/atc_mod.sv
// Iterative remainder unit: 32-bit dividend modulo a small prime, four bits a cycle.
`default_nettype none

module atc_mod import atc_pkg::*; (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                start_i,
  input  wire logic [OFFSET_W-1:0] dividend_i,
  input  wire logic [PRIME_W-1:0]  divisor_i,
  output logic                     busy_o,
  output logic      [PRIME_W-1:0]  rem_o
);

  logic                 busy_q, busy_d;
  logic [MOD_CNT_W-1:0] cnt_q, cnt_d;
  logic [OFFSET_W-1:0]  shift_q;
  logic [PRIME_W-1:0]   rem_q;
  logic [PRIME_W-1:0]   rem_step;
  logic [PRIME_W:0]     trial;

  always_comb begin
    rem_step = rem_q;
    trial    = '0;
    for (int j = 0; j < MOD_DIGIT_W; j++) begin
      trial = {rem_step, shift_q[OFFSET_W-1-j]};
      if (trial >= {1'b0, divisor_i}) begin
        trial = trial - {1'b0, divisor_i};
      end
      rem_step = trial[PRIME_W-1:0];
    end
  end

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
    end else if (busy_q) begin
      cnt_d = cnt_q + MOD_CNT_W'(1);
      if (cnt_q == MOD_CNT_W'(MOD_CYCLES - 1)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      shift_q <= dividend_i;
      rem_q   <= '0;
    end else if (busy_q) begin
      shift_q <= {shift_q[OFFSET_W-MOD_DIGIT_W-1:0], {MOD_DIGIT_W{1'b0}}};
      rem_q   <= rem_step;
    end
  end

  assign busy_o = busy_q;
  assign rem_o  = rem_q;

endmodule

`default_nettype wire

// File: hdl/atc_useq.sv
// Microcode sequencer: step counter, control store and conditional jumps.
`default_nettype none

module atc_useq import atc_pkg::*; (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire status_t status_i,
  output ctrl_t        ctrl_o
);

  localparam logic [STEP_W-1:0] STEP_IDLE    = 4'd0;
  localparam logic [STEP_W-1:0] STEP_INIT    = 4'd1;
  localparam logic [STEP_W-1:0] STEP_PRIME   = 4'd2;
  localparam logic [STEP_W-1:0] STEP_CLEAR   = 4'd3;
  localparam logic [STEP_W-1:0] STEP_RDOFF   = 4'd4;
  localparam logic [STEP_W-1:0] STEP_MODGO   = 4'd5;
  localparam logic [STEP_W-1:0] STEP_MODWAIT = 4'd6;
  localparam logic [STEP_W-1:0] STEP_MARK    = 4'd7;
  localparam logic [STEP_W-1:0] STEP_SCANSET = 4'd8;
  localparam logic [STEP_W-1:0] STEP_SREAD   = 4'd9;
  localparam logic [STEP_W-1:0] STEP_STEST   = 4'd10;
  localparam logic [STEP_W-1:0] STEP_SLOOP   = 4'd11;
  localparam logic [STEP_W-1:0] STEP_COVERED = 4'd12;
  localparam logic [STEP_W-1:0] STEP_NEXTP   = 4'd13;
  localparam logic [STEP_W-1:0] STEP_EMIT    = 4'd15;

  logic [STEP_W-1:0] pc_q, pc_d;
  ctrl_t             word;
  logic              jump;

  always_comb begin
    word        = '0;
    word.cond   = COND_NEVER;
    word.target = STEP_IDLE;
    unique case (pc_q)
      STEP_IDLE: begin
        word.in_open = 1'b1;
        word.cond    = COND_NO_START;
        word.target  = STEP_IDLE;
      end
      STEP_INIT: begin
        word.i_clr   = 1'b1;
        word.res_set = 1'b1;
        word.cond    = COND_OVERFLOW;
        word.target  = STEP_EMIT;
      end
      STEP_PRIME: begin
        word.p_load = 1'b1;
        word.r_clr  = 1'b1;
        word.k_clr  = 1'b1;
        word.cond   = COND_P_GT_N;
        word.target = STEP_EMIT;
      end
      STEP_CLEAR: begin
        word.mark_we = 1'b1;
        word.r_inc   = 1'b1;
        word.cond    = COND_R_NOT_LAST;
        word.target  = STEP_CLEAR;
      end
      STEP_RDOFF: begin
        word.cond = COND_NEVER;
      end
      STEP_MODGO: begin
        word.mod_start = 1'b1;
      end
      STEP_MODWAIT: begin
        word.cond   = COND_MOD_BUSY;
        word.target = STEP_MODWAIT;
      end
      STEP_MARK: begin
        word.mark_we       = 1'b1;
        word.mark_bit      = 1'b1;
        word.mark_from_rem = 1'b1;
        word.k_inc         = 1'b1;
        word.cond          = COND_K_NOT_LAST;
        word.target        = STEP_RDOFF;
      end
      STEP_SCANSET: begin
        word.r_clr = 1'b1;
      end
      STEP_SREAD: begin
        word.cond = COND_NEVER;
      end
      STEP_STEST: begin
        word.r_inc  = 1'b1;
        word.cond   = COND_MARK_CLEAR;
        word.target = STEP_NEXTP;
      end
      STEP_SLOOP: begin
        word.cond   = COND_R_NE_P;
        word.target = STEP_SREAD;
      end
      STEP_COVERED: begin
        word.res_clr = 1'b1;
        word.cond    = COND_ALWAYS;
        word.target  = STEP_EMIT;
      end
      STEP_NEXTP: begin
        word.i_inc  = 1'b1;
        word.cond   = COND_ALWAYS;
        word.target = STEP_PRIME;
      end
      STEP_EMIT: begin
        word.out_load = 1'b1;
        word.cond     = COND_OUT_BLOCKED;
        word.target   = STEP_EMIT;
      end
      default: begin
        word.cond   = COND_ALWAYS;
        word.target = STEP_IDLE;
      end
    endcase
  end

  always_comb begin
    unique case (word.cond)
      COND_NEVER:       jump = 1'b0;
      COND_ALWAYS:      jump = 1'b1;
      COND_NO_START:    jump = !status_i.start;
      COND_OVERFLOW:    jump = status_i.overflow;
      COND_P_GT_N:      jump = status_i.p_gt_n;
      COND_R_NOT_LAST:  jump = status_i.r_not_last;
      COND_MOD_BUSY:    jump = status_i.mod_busy;
      COND_K_NOT_LAST:  jump = status_i.k_not_last;
      COND_MARK_CLEAR:  jump = status_i.mark_clear;
      COND_R_NE_P:      jump = status_i.r_ne_p;
      COND_OUT_BLOCKED: jump = status_i.out_blocked;
      default:          jump = 1'b1;
    endcase
  end

  // The emit step is the last one, so falling through wraps to idle.
  assign pc_d = jump ? word.target : pc_q + STEP_W'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= STEP_IDLE;
    end else begin
      pc_q <= pc_d;
    end
  end

  assign ctrl_o = word;

endmodule

`default_nettype wire

// File: hdl/admissible_tuple_checker.sv
// Top level of the admissible tuple checker: datapath, stores and output register.
// Offsets load one per cycle while not stalled; the final offset starts the test.
// The test checks each prime p <= n for n offsets until one has all residues hit.
// Each offset's residue is computed by the four-bit-per-cycle remainder unit.
// The result is registered on emit; oversized tuples skip the test, answering 1.
// Reset clears the count, flags and sequencer; the mark store needs no clearing.
`default_nettype none
`include "admissible_tuple_checker_macros.svh"

module admissible_tuple_checker import atc_pkg::*; (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire logic [OFFSET_W-1:0] offset_i,
  input  wire logic                last_offset_i,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output logic                     admissible_o
);

  ctrl_t   ctrl;
  status_t status;

  logic [COUNT_W-1:0]     count_q, count_d;
  logic                   overflow_q, overflow_d;
  logic [PRIME_IDX_W-1:0] i_q, i_d;
  logic [COUNT_W-1:0]     k_q, k_d;
  logic [PRIME_W-1:0]     r_q, r_d;
  logic [PRIME_W-1:0]     p_q;
  logic                   res_q, res_d;
  logic                   out_valid_q, out_valid_d;
  logic                   admissible_q;

  logic                   in_fire;
  logic                   store_we;
  logic [OFFSET_W-1:0]    store_rdata;
  logic                   mod_busy;
  logic [PRIME_W-1:0]     mod_rem;
  logic [MARK_AW-1:0]     mark_waddr;
  logic                   mark_rdata;
  logic                   out_blocked;
  logic                   emit_fire;

  assign in_stall_o  = !ctrl.in_open;
  assign in_fire     = in_valid_i && ctrl.in_open;
  assign store_we    = in_fire && (count_q < COUNT_W'(MAX_OFFSETS));
  assign out_blocked = out_valid_q && out_stall_i;
  assign emit_fire   = ctrl.out_load && !out_blocked;
  assign mark_waddr  = ctrl.mark_from_rem ? mod_rem : r_q;

  atc_useq u_useq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .status_i (status),
    .ctrl_o   (ctrl)
  );

  atc_ram #(
    .WIDTH (OFFSET_W),
    .DEPTH (MAX_OFFSETS)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (store_we),
    .waddr_i (count_q[STORE_AW-1:0]),
    .wdata_i (offset_i),
    .raddr_i (k_q[STORE_AW-1:0]),
    .rdata_o (store_rdata)
  );

  atc_ram #(
    .WIDTH (1),
    .DEPTH (MARK_DEPTH)
  ) u_marks (
    .clk_i   (clk_i),
    .we_i    (ctrl.mark_we),
    .waddr_i (mark_waddr),
    .wdata_i (ctrl.mark_bit),
    .raddr_i (r_q),
    .rdata_o (mark_rdata)
  );

  atc_mod u_mod (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (ctrl.mod_start),
    .dividend_i (store_rdata),
    .divisor_i  (p_q),
    .busy_o     (mod_busy),
    .rem_o      (mod_rem)
  );

  always_comb begin
    status.start       = in_valid_i && last_offset_i;
    status.overflow    = overflow_q;
    status.p_gt_n      = prime_at(i_q) > PRIME_W'(count_q);
    status.r_not_last  = r_q != (p_q - PRIME_W'(1));
    status.mod_busy    = mod_busy;
    status.k_not_last  = k_q != (count_q - COUNT_W'(1));
    status.mark_clear  = !mark_rdata;
    status.r_ne_p      = r_q != p_q;
    status.out_blocked = out_blocked;
  end

  always_comb begin
    count_d    = count_q;
    overflow_d = overflow_q;
    if (emit_fire) begin
      count_d    = '0;
      overflow_d = 1'b0;
    end else if (in_fire) begin
      if (count_q < COUNT_W'(MAX_OFFSETS)) begin
        count_d = count_q + COUNT_W'(1);
      end else begin
        overflow_d = 1'b1;
      end
    end

    i_d = i_q;
    if (ctrl.i_clr) begin
      i_d = '0;
    end else if (ctrl.i_inc) begin
      i_d = i_q + PRIME_IDX_W'(1);
    end

    k_d = k_q;
    if (ctrl.k_clr) begin
      k_d = '0;
    end else if (ctrl.k_inc) begin
      k_d = k_q + COUNT_W'(1);
    end

    r_d = r_q;
    if (ctrl.r_clr) begin
      r_d = '0;
    end else if (ctrl.r_inc) begin
      r_d = r_q + PRIME_W'(1);
    end

    res_d = res_q;
    if (ctrl.res_set) begin
      res_d = 1'b1;
    end else if (ctrl.res_clr) begin
      res_d = 1'b0;
    end

    out_valid_d = out_valid_q && out_stall_i;
    if (emit_fire) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      overflow_q  <= 1'b0;
      i_q         <= '0;
      k_q         <= '0;
      r_q         <= '0;
      res_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      overflow_q  <= overflow_d;
      i_q         <= i_d;
      k_q         <= k_d;
      r_q         <= r_d;
      res_q       <= res_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.p_load) begin
      p_q <= prime_at(i_q);
    end
    if (emit_fire) begin
      admissible_q <= res_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign admissible_o = admissible_q;

  `ATC_HOLDS(a_count_bound, 1'b1, count_q <= COUNT_W'(MAX_OFFSETS), "offset count overran the store")
  `ATC_HOLDS(a_mark_in_range, ctrl.mark_we, mark_waddr < p_q, "mark write beyond current prime")
  `ATC_HOLDS(a_mod_start_idle, ctrl.mod_start, !mod_busy, "remainder unit restarted while busy")
  `ATC_FOLLOWS(a_emit_clears, emit_fire, out_valid_q && count_q == '0 && !overflow_q, "tuple state not cleared after result")

endmodule

`default_nettype wire

// File: bench/tb_top.sv
// Self-checking testbench for the admissible tuple checker: random tuples, stalls and a scoreboard.
`timescale 1ns / 1ps

module tb_top;
  import atc_pkg::*;

  typedef logic [OFFSET_W-1:0] offset_list_t[$];

  localparam int unsigned ITEM_TARGET = 1350;
  localparam int unsigned CALM_ITEMS  = 150;
  localparam int unsigned HOLD_CYCLES = 20000;
  localparam int unsigned PRIMORIAL13 = 30030;
  localparam int unsigned PATTERN [15] = '{0, 2, 6, 8, 12, 18, 20, 26, 30, 32, 36, 42, 48, 50, 56};

  class tuple_admissibility;
    logic [OFFSET_W-1:0] offsets[$];
    bit                  overflow;
    bit                  verdicts_due[$];
    int unsigned         errors;

    function bit admissible_now();
      bit marks [MARK_DEPTH];
      int unsigned p;
      bit covered;
      for (int i = 0; i < offsets.size() && i < PRIME_COUNT; i++) begin
        p = PRIME_TABLE[i];
        foreach (marks[r]) marks[r] = 1'b0;
        foreach (offsets[k]) marks[offsets[k] % p] = 1'b1;
        covered = 1'b1;
        for (int r = 0; r < p; r++) begin
          if (!marks[r]) begin
            covered = 1'b0;
            break;
          end
        end
        if (covered) return 1'b0;
      end
      return 1'b1;
    endfunction

    function void take_offset(logic [OFFSET_W-1:0] off, logic last);
      if (offsets.size() < MAX_OFFSETS) begin
        offsets.push_back(off);
      end else begin
        overflow = 1'b1;
      end
      if (last) begin
        verdicts_due.push_back(overflow ? 1'b1 : admissible_now());
        offsets.delete();
        overflow = 1'b0;
      end
    endfunction

    function void compare_verdict(logic got);
      bit want;
      if (verdicts_due.size() == 0) begin
        $error("admissible: expected no result, got %0b", got);
        errors++;
      end else begin
        want = verdicts_due.pop_front();
        if (got !== want) begin
          $error("admissible: expected %0b, got %0b", want, got);
          errors++;
        end
      end
    endfunction

    function int unsigned pending();
      return verdicts_due.size();
    endfunction
  endclass

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                in_valid_i = 1'b0;
  logic                in_stall_o;
  logic [OFFSET_W-1:0] offset_i = '0;
  logic                last_offset_i = 1'b0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  logic                admissible_o;

  tuple_admissibility verdicts = new();
  int unsigned        items_sent = 0;
  int unsigned        gap_pct = 0;
  bit                 calm = 1'b0;
  bit                 hold_req = 1'b0;

  admissible_tuple_checker uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .offset_i      (offset_i),
    .last_offset_i (last_offset_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .admissible_o  (admissible_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #60_000_000;
    $display("tb_top: done, errors");
    $finish;
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) verdicts.compare_verdict(admissible_o);
  end

  initial begin
    @(posedge rst_ni);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall_i <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end else if (!calm && $urandom_range(0, 2) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 19)) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      repeat ($urandom_range(1, 40)) @(posedge clk_i);
    end
  end

  task automatic send_offset(input logic [OFFSET_W-1:0] off, input logic last);
    in_valid_i    <= 1'b1;
    offset_i      <= off;
    last_offset_i <= last;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    verdicts.take_offset(off, last);
    items_sent++;
  endtask

  task automatic pause_input(input int unsigned cycles);
    in_valid_i <= 1'b0;
    repeat (cycles) @(posedge clk_i);
  endtask

  task automatic send_tuple(input offset_list_t offs);
    foreach (offs[j]) begin
      send_offset(offs[j], j == offs.size() - 1);
      if (!calm && $urandom_range(0, 99) < gap_pct) pause_input($urandom_range(1, 19));
    end
  endtask

  function automatic offset_list_t random_tuple();
    offset_list_t        offs;
    int unsigned         n;
    int unsigned         kind;
    int unsigned         sel;
    logic [OFFSET_W-1:0] base;
    sel = $urandom_range(0, 99);
    if (sel < 70) n = $urandom_range(1, 6);
    else if (sel < 95) n = $urandom_range(7, 16);
    else n = $urandom_range(17, 40);
    kind = $urandom_range(0, 3);
    base = PRIMORIAL13 * $urandom_range(0, 140000);
    for (int j = 0; j < n; j++) begin
      case (kind)
        0: offs.push_back(base + PATTERN[j % 15] + 210 * (j / 15));
        1: offs.push_back($urandom);
        2: offs.push_back(PRIMORIAL13 * $urandom_range(0, 143000));
        default: offs.push_back($urandom_range(0, 1023));
      endcase
    end
    if ($urandom_range(0, 9) == 0) offs[$urandom_range(0, n - 1)] = $urandom;
    return offs;
  endfunction

  function automatic offset_list_t long_tuple(input int unsigned n);
    offset_list_t offs;
    repeat (n) offs.push_back($urandom);
    return offs;
  endfunction

  initial begin
    bit hold_issued;
    hold_issued = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_tuple('{32'd0});
    send_tuple('{32'hFFFF_FFFF});
    send_tuple('{32'd0, 32'd1});
    send_tuple('{32'd0, 32'd2});
    send_tuple('{32'd0, 32'd2, 32'd4});
    send_tuple('{32'd0, 32'd2, 32'd6});
    send_tuple('{32'hFFFF_FFFF, 32'hFFFF_FFFE});
    send_tuple('{32'd0, 32'd2, 32'd6, 32'd8, 32'd12});
    send_tuple('{32'd0, 32'hAAAA_AAAA, 32'h5555_5555, 32'h8000_0000});

    // One offset too many for the store, then a tuple that fills it exactly.
    gap_pct = 10;
    send_tuple(long_tuple(MAX_OFFSETS + 1));
    send_tuple(long_tuple(MAX_OFFSETS));

    while (items_sent < ITEM_TARGET) begin
      if (!hold_issued && items_sent >= 600) begin
        hold_req    = 1'b1;
        hold_issued = 1'b1;
      end
      calm    = items_sent >= ITEM_TARGET - CALM_ITEMS;
      gap_pct = $urandom_range(0, 1) ? 25 : 0;
      send_tuple(random_tuple());
    end
    in_valid_i <= 1'b0;

    while (verdicts.pending() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (verdicts.errors == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule
